### rtl/palc_pkg.sv
package palc_pkg;

  localparam int unsigned PosW = 8;
  localparam int unsigned ValW = 32;
  localparam int unsigned LenOutW = 8;

  // Command codes.
  localparam logic [1:0] CmdRead   = 2'd0;
  localparam logic [1:0] CmdInsert = 2'd1;
  localparam logic [1:0] CmdDelete = 2'd2;

  // Status codes.
  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StFull   = 2'd1;
  localparam logic [1:0] StBadPos = 2'd2;
  localparam logic [1:0] StEmpty  = 2'd3;

  typedef struct packed {
    logic [1:0]             command;
    logic [PosW-1:0]        position;
    logic signed [ValW-1:0] value;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]             status;
    logic signed [ValW-1:0] read_value;
    logic [LenOutW-1:0]     current_length;
  } res_word_t;

  // Shift control broadcast to every cell of the chain.
  typedef struct packed {
    logic            ins;
    logic            del;
    logic [PosW-1:0] idx;
  } cell_op_t;

endpackage

### rtl/palc_cell.sv
module palc_cell #(
  parameter int unsigned EW  = 32,
  parameter int unsigned IDX = 0
) (
  input  logic               clk_i,
  input  palc_pkg::cell_op_t op_i,
  input  logic [EW-1:0]      value_i,
  input  logic [EW-1:0]      left_i,
  input  logic [EW-1:0]      right_i,
  output logic [EW-1:0]      data_o,
  output logic [EW-1:0]      rd_o
);

  localparam logic [palc_pkg::PosW-1:0] MyIdx = palc_pkg::PosW'(IDX);

  logic [EW-1:0] data_q;
  logic [EW-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (op_i.ins) begin
      if (MyIdx == op_i.idx) begin
        data_d = value_i;
      end else if (MyIdx > op_i.idx) begin
        data_d = left_i;
      end
    end else if (op_i.del) begin
      if (MyIdx >= op_i.idx) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // Only the addressed cell drives its word onto the read bus.
  assign rd_o   = (MyIdx == op_i.idx) ? data_q : '0;

endmodule

### rtl/positional_array_list_core.sv
// Channel  | Ports                     | Direction | Handshake
// command  | start, busy, cmd_i        | in        | taken when start is high and busy is low
// result   | done_o, res_o             | out       | valid for the one cycle done_o is high
//
// The result word appears on res_o in the cycle after the command is taken,
// and busy never rises, so a new command may be issued in every cycle. An
// insert or delete is done by the shift chain, in which every cell past the
// insert position, or from the delete position on, moves its word to a neighbor.
// Reset clears the list length and the result strobe; the cell contents are
// left as they are. The receiver cannot stall, so each result word is shown
// exactly once.
module positional_array_list_core #(
  parameter int unsigned LIST_DEPTH    = 128,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  palc_pkg::cmd_word_t  cmd_i,
  output logic                 done_o,
  output palc_pkg::res_word_t  res_o
);

  localparam int unsigned EW   = ELEMENT_WIDTH;
  localparam int unsigned LenW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned CmpW = palc_pkg::PosW + 1;

  // The list length lives here; the elements live in the cell chain.
  logic [LenW-1:0] len_q;
  logic [LenW-1:0] len_d;

  logic                done_q;
  palc_pkg::res_word_t res_q;
  palc_pkg::res_word_t res_d;

  logic               take;
  palc_pkg::cell_op_t op;
  logic [EW-1:0]      value_elem;
  logic [63:0]        value_ext;

  logic [EW-1:0] cell_data [LIST_DEPTH];
  logic [EW-1:0] cell_rd   [LIST_DEPTH];
  logic [EW-1:0] rd_bus;
  logic [63:0]   rd_ext;

  logic [CmpW-1:0] pos_c;
  logic [CmpW-1:0] len_c;
  logic            pos_zero;
  logic            list_full;
  logic            list_empty;

  assign busy = 1'b0;
  assign take = start && !busy;

  assign pos_c      = {1'b0, cmd_i.position};
  assign len_c      = CmpW'(len_q);
  assign pos_zero   = (cmd_i.position == '0);
  assign list_full  = (len_q == LenW'(LIST_DEPTH));
  assign list_empty = (len_q == '0);

  // The input value is sign-extended and trimmed to the element width.
  assign value_ext  = 64'(signed'(cmd_i.value));
  assign value_elem = value_ext[EW-1:0];

  // The read bus is the OR of every cell's gated word: at most one cell is
  // addressed, so this yields the element at the requested position.
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  // A stored element is sign-extended from its width before going out.
  assign rd_ext = 64'(signed'(rd_bus));

  // Command decode. The status checks follow the priority of each command:
  // full before position for an insert, empty before position for a delete.
  always_comb begin
    op.ins = 1'b0;
    op.del = 1'b0;
    op.idx = cmd_i.position - palc_pkg::PosW'(1);
    len_d  = len_q;
    res_d.status     = palc_pkg::StBadPos;
    res_d.read_value = '0;
    case (cmd_i.command)
      palc_pkg::CmdRead: begin
        if (!pos_zero && pos_c <= len_c) begin
          res_d.status     = palc_pkg::StOk;
          res_d.read_value = rd_ext[palc_pkg::ValW-1:0];
        end
      end
      palc_pkg::CmdInsert: begin
        if (list_full) begin
          res_d.status = palc_pkg::StFull;
        end else if (!pos_zero && pos_c <= len_c + CmpW'(1)) begin
          res_d.status = palc_pkg::StOk;
          op.ins       = take;
          len_d        = len_q + LenW'(1);
        end
      end
      palc_pkg::CmdDelete: begin
        if (list_empty) begin
          res_d.status = palc_pkg::StEmpty;
        end else if (!pos_zero && pos_c <= len_c) begin
          res_d.status = palc_pkg::StOk;
          op.del       = take;
          len_d        = len_q - LenW'(1);
        end
      end
      default: begin
        res_d.status = palc_pkg::StBadPos;
      end
    endcase
    res_d.current_length = palc_pkg::LenOutW'(len_d);
  end

  // The chain of cells: each cell sees its left and right neighbor, so an
  // insert shifts the tail up and a delete shifts it down.
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic [EW-1:0] left_w;
    logic [EW-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = cell_data[g-1];
    end

    if (g == LIST_DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = cell_data[g+1];
    end

    palc_cell #(
      .EW  (EW),
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .value_i (value_elem),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[g]),
      .rd_o    (cell_rd[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= take;
      if (take) begin
        len_q <= len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned Depth       = 128;
  localparam int unsigned RandomWords = 600;
  localparam int unsigned MaxReports  = 60;

  // The one command code that the block does not use.
  localparam logic [1:0] CmdUnused = 2'd3;

  // Tracks the list contents as the block should hold them. Every accepted
  // command word is applied here at once, and the result word it must give is
  // queued. Result words from the block are matched in order against that queue.
  class list_tracker;
    logic signed [palc_pkg::ValW-1:0] elems[$];
    palc_pkg::res_word_t              awaited[$];
    int unsigned                      errors;
    int unsigned                      reports;
    int unsigned                      peak;
    int unsigned                      cmd_count[4];
    int unsigned                      status_count[4];

    function int unsigned length();
      return elems.size();
    endfunction

    function void note_command(palc_pkg::cmd_word_t w);
      palc_pkg::res_word_t r;
      int unsigned         len;
      int unsigned         pos;
      len = elems.size();
      pos = w.position;
      r.status = palc_pkg::StBadPos;
      r.read_value = '0;
      case (w.command)
        palc_pkg::CmdRead: begin
          if (pos >= 1 && pos <= len) begin
            r.read_value = elems[pos-1];
            r.status = palc_pkg::StOk;
          end
        end
        palc_pkg::CmdInsert: begin
          // A full list is reported before the position is looked at.
          if (len >= Depth) begin
            r.status = palc_pkg::StFull;
          end else if (pos >= 1 && pos <= len + 1) begin
            elems.insert(pos - 1, w.value);
            r.status = palc_pkg::StOk;
          end
        end
        palc_pkg::CmdDelete: begin
          // An empty list is reported before the position is looked at.
          if (len == 0) begin
            r.status = palc_pkg::StEmpty;
          end else if (pos >= 1 && pos <= len) begin
            elems.delete(pos - 1);
            r.status = palc_pkg::StOk;
          end
        end
        default: begin
        end
      endcase
      r.current_length = palc_pkg::LenOutW'(elems.size());
      if (elems.size() > peak) begin
        peak = elems.size();
      end
      cmd_count[w.command]++;
      status_count[r.status]++;
      awaited.push_back(r);
    endfunction

    function void flag(string msg);
      errors++;
      if (reports < MaxReports) begin
        $display("%0t: %s", $time, msg);
      end else if (reports == MaxReports) begin
        $display("%0t: further mismatch reports suppressed", $time);
      end
      reports++;
    endfunction

    function void check_result(palc_pkg::res_word_t got);
      palc_pkg::res_word_t exp;
      if (awaited.size() == 0) begin
        flag($sformatf("result word %h arrived with none expected", got));
        return;
      end
      exp = awaited.pop_front();
      if (got.status !== exp.status) begin
        flag($sformatf("status expected %0d got %0d", exp.status, got.status));
      end
      if (got.read_value !== exp.read_value) begin
        flag($sformatf("read_value expected %h got %h",
                       exp.read_value, got.read_value));
      end
      if (got.current_length !== exp.current_length) begin
        flag($sformatf("current_length expected %0d got %0d",
                       exp.current_length, got.current_length));
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  palc_pkg::cmd_word_t cmd_i;
  logic                done_o;
  palc_pkg::res_word_t res_o;

  list_tracker book = new();

  // Random stimulus alternates between filling the list up to and past its
  // depth and draining it down to empty, so both the full and the empty
  // checks are reached repeatedly.
  bit          growing = 1'b1;
  int unsigned burst_left;

  positional_array_list_core #(
    .LIST_DEPTH   (Depth),
    .ELEMENT_WIDTH(palc_pkg::ValW)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_i (cmd_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // The result strobe is sampled at the rising edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      book.check_result(res_o);
    end
  end

  // Gap before the next command word. Most gaps are short, a few are long,
  // and now and then a burst of back-to-back words runs with no gap at all.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      burst_left = $urandom_range(20, 40);
      return 0;
    end
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic palc_pkg::cmd_word_t make_word(logic [1:0] command,
                                                    int unsigned position,
                                                    logic [palc_pkg::ValW-1:0] value);
    palc_pkg::cmd_word_t w;
    w.command = command;
    w.position = palc_pkg::PosW'(position);
    w.value = value;
    return w;
  endfunction

  // Any command code and a position that is either fully random, zero, the
  // largest position, or one of the boundaries of the current length.
  function automatic palc_pkg::cmd_word_t noise_word(int unsigned len);
    palc_pkg::cmd_word_t w;
    int unsigned         pick;
    w.command = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 9);
    case (pick)
      0:       w.position = '0;
      1:       w.position = palc_pkg::PosW'(len);
      2:       w.position = palc_pkg::PosW'(len + 1);
      3:       w.position = palc_pkg::PosW'(len + 2);
      4:       w.position = '1;
      default: w.position = palc_pkg::PosW'($urandom_range(0, 255));
    endcase
    pick = $urandom_range(0, 9);
    case (pick)
      0:       w.value = 32'h8000_0000;
      1:       w.value = 32'h7fff_ffff;
      2:       w.value = '1;
      3:       w.value = '0;
      default: w.value = $urandom();
    endcase
    return w;
  endfunction

  function automatic palc_pkg::cmd_word_t shaped_word();
    palc_pkg::cmd_word_t w;
    int unsigned         len;
    int unsigned         roll;
    len = book.length();
    // Hold at the extremes for a few words before turning around.
    if (growing && len == Depth && $urandom_range(0, 7) == 0) begin
      growing = 1'b0;
    end else if (!growing && len == 0 && $urandom_range(0, 3) == 0) begin
      growing = 1'b1;
    end
    w = noise_word(len);
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      return w;
    end
    if (growing) begin
      if (roll < 85 || len == 0) begin
        w.command = palc_pkg::CmdInsert;
        w.position = palc_pkg::PosW'($urandom_range(1, len + 1));
      end else begin
        w.command = palc_pkg::CmdRead;
        w.position = palc_pkg::PosW'($urandom_range(1, len));
      end
    end else begin
      if (len == 0) begin
        w.command = palc_pkg::CmdDelete;
      end else if (roll < 85) begin
        w.command = palc_pkg::CmdDelete;
        w.position = palc_pkg::PosW'($urandom_range(1, len));
      end else begin
        w.command = palc_pkg::CmdRead;
        w.position = palc_pkg::PosW'($urandom_range(1, len));
      end
    end
    return w;
  endfunction

  // Presents one command word and holds it until the block takes it. Start
  // stays high across back-to-back words and is lowered only for a gap.
  task automatic issue(input palc_pkg::cmd_word_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i) start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= w;
    do @(posedge clk_i); while (busy);
    book.note_command(w);
  endtask

  task automatic run_directed();
    // Empty list: reads are out of range and deletes report empty even at
    // position zero.
    issue(make_word(palc_pkg::CmdRead,   1, 32'd5));
    issue(make_word(palc_pkg::CmdDelete, 1, 32'd0));
    issue(make_word(palc_pkg::CmdDelete, 0, 32'd0));
    // Inserts at position zero and past the end of the list are rejected.
    issue(make_word(palc_pkg::CmdInsert, 0, 32'h1234_5678));
    issue(make_word(palc_pkg::CmdInsert, 2, 32'h1234_5678));
    // The unused command code changes nothing.
    issue(make_word(CmdUnused,           1, 32'hffff_ffff));
    // Build a short list with extreme values, inserting at the back, the
    // front and the middle.
    issue(make_word(palc_pkg::CmdInsert, 1, 32'h8000_0000));
    issue(make_word(palc_pkg::CmdInsert, 2, 32'h7fff_ffff));
    issue(make_word(palc_pkg::CmdInsert, 1, 32'hffff_ffff));
    issue(make_word(palc_pkg::CmdInsert, 2, 32'h0000_0000));
    issue(make_word(palc_pkg::CmdInsert, 255, 32'h5555_aaaa));
    issue(make_word(palc_pkg::CmdRead,   0, 32'd0));
    issue(make_word(palc_pkg::CmdRead,   1, 32'd0));
    issue(make_word(palc_pkg::CmdRead,   2, 32'd0));
    issue(make_word(palc_pkg::CmdRead,   3, 32'd0));
    issue(make_word(palc_pkg::CmdRead,   4, 32'd0));
    issue(make_word(palc_pkg::CmdRead,   5, 32'd0));
    issue(make_word(palc_pkg::CmdRead,   255, 32'd0));
    // Deletes at bad positions, then from the middle, the end and the front.
    issue(make_word(palc_pkg::CmdDelete, 0, 32'd0));
    issue(make_word(palc_pkg::CmdDelete, 5, 32'd0));
    issue(make_word(palc_pkg::CmdDelete, 2, 32'd0));
    issue(make_word(palc_pkg::CmdDelete, 3, 32'd0));
    issue(make_word(palc_pkg::CmdDelete, 1, 32'd0));
    issue(make_word(palc_pkg::CmdRead,   1, 32'd0));
    issue(make_word(palc_pkg::CmdDelete, 1, 32'd0));
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    run_directed();
    for (int i = 0; i < RandomWords; i++) begin
      issue(shaped_word());
    end
    @(negedge clk_i) start <= 1'b0;

    // Let the last result words come out, then watch a few more cycles for
    // anything spurious.
    while (book.awaited.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("Ran %0d reads, %0d inserts, %0d deletes and %0d unused-code words;",
             book.cmd_count[palc_pkg::CmdRead], book.cmd_count[palc_pkg::CmdInsert],
             book.cmd_count[palc_pkg::CmdDelete], book.cmd_count[CmdUnused]);
    $display("peak length %0d. Statuses seen: ok %0d, full %0d, bad position %0d, empty %0d.",
             book.peak, book.status_count[palc_pkg::StOk],
             book.status_count[palc_pkg::StFull], book.status_count[palc_pkg::StBadPos],
             book.status_count[palc_pkg::StEmpty]);
    if (book.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Far beyond the slowest legal run, which takes well under a millisecond.
  initial begin
    #5000000;
    $display("Timed out with %0d result words outstanding.", book.awaited.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### positional_array_list_core.f
rtl/palc_pkg.sv
rtl/palc_cell.sv
rtl/positional_array_list_core.sv
bench/tb.sv
